FILE: rtl/tssr_pkg.sv
`timescale 1ns / 1ps

package tssr_pkg;

	localparam int LINE_WIDTH_DEF       = 160;
	localparam int SPRITES_PER_LINE_DEF = 10;
	localparam int SPRITE_COUNT_DEF     = 40;

	localparam int VM_AW     = 13;
	localparam int CFG_IDX_W = 3;
	localparam int SPR_IDX_W = 6;
	localparam int GROUP_W   = 6;

	localparam logic [1:0] OP_VRAM   = 2'd0;
	localparam logic [1:0] OP_OAM    = 2'd1;
	localparam logic [1:0] OP_RENDER = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_LCD_CONTROL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCROLL_X    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCROLL_Y    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_X    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_Y    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BG_PAL      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPR_PAL_A   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPR_PAL_B   = 3'd7;

	localparam logic [7:0] WIN_Y_MAX = 8'd143;
	localparam logic [7:0] WIN_X_MIN = 8'd7;
	localparam logic [7:0] WIN_X_MAX = 8'd166;

	typedef struct packed {
		logic [7:0] lcd_control;
		logic [7:0] scroll_x;
		logic [7:0] scroll_y;
		logic [7:0] window_x;
		logic [7:0] window_y;
		logic [7:0] bg_palette;
		logic [7:0] sprite_palette_a;
		logic [7:0] sprite_palette_b;
	} cfg_t;

	typedef struct packed {
		logic                 clear;
		logic                 push;
		logic [7:0]           x;
		logic [SPR_IDX_W-1:0] idx;
	} sort_ctl_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PX_BEGIN,
		ST_PX_WIN,
		ST_F_MAP,
		ST_F_TILE,
		ST_F_LO,
		ST_F_HI,
		ST_PX_WRITE,
		ST_SC_SCAN,
		ST_SC_END,
		ST_SC_DONE,
		ST_SP_ATTR,
		ST_SP_ADDR,
		ST_SP_LO,
		ST_SP_HI,
		ST_SP_PRD,
		ST_SP_PWR,
		ST_OUT_RD,
		ST_OUT_WAIT,
		ST_OUT_LOAD
	} state_t;

	function automatic logic [1:0] shade(input logic [7:0] pal, input logic [1:0] c);
		return pal[{c, 1'b0} +: 2];
	endfunction

endpackage

FILE: rtl/tssr_in_if.sv
`timescale 1ns / 1ps

interface tssr_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [12:0] address;
	logic [7:0]  data;
	logic [7:0]  line;

	modport source(output valid, output operation, output address, output data,
		output line, input ready);
	modport sink(input valid, input operation, input address, input data,
		input line, output ready);
endinterface

FILE: rtl/tssr_out_if.sv
`timescale 1ns / 1ps

interface tssr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixels;
	logic [5:0] group;
	logic       last;

	modport source(output valid, output pixels, output group, output last, input ready);
	modport sink(input valid, input pixels, input group, input last, output ready);
endinterface

FILE: rtl/tssr_regs.sv
`timescale 1ns / 1ps

module tssr_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [tssr_pkg::CFG_IDX_W-1:0] index,
	input  logic [7:0]                     wdata,
	output tssr_pkg::cfg_t                 cfg
);
	import tssr_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (index)
				REG_LCD_CONTROL: cfg_q.lcd_control      <= wdata;
				REG_SCROLL_X:    cfg_q.scroll_x         <= wdata;
				REG_SCROLL_Y:    cfg_q.scroll_y         <= wdata;
				REG_WINDOW_X:    cfg_q.window_x         <= wdata;
				REG_WINDOW_Y:    cfg_q.window_y         <= wdata;
				REG_BG_PAL:      cfg_q.bg_palette       <= wdata;
				REG_SPR_PAL_A:   cfg_q.sprite_palette_a <= wdata;
				REG_SPR_PAL_B:   cfg_q.sprite_palette_b <= wdata;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

FILE: rtl/tssr_sprite_sort.sv
`timescale 1ns / 1ps

module tssr_sprite_sort #(
	parameter int SPRITES_PER_LINE = tssr_pkg::SPRITES_PER_LINE_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  tssr_pkg::sort_ctl_t                   ctl,
	input  logic [((SPRITES_PER_LINE > 1) ? $clog2(SPRITES_PER_LINE) : 1)-1:0] rd_sel,
	output logic [tssr_pkg::SPR_IDX_W-1:0]        rd_idx,
	output logic [$clog2(SPRITES_PER_LINE+1)-1:0] count
);
	import tssr_pkg::*;

	localparam int CW = $clog2(SPRITES_PER_LINE + 1);

	logic                 vld_q [SPRITES_PER_LINE];
	logic [7:0]           x_q   [SPRITES_PER_LINE];
	logic [SPR_IDX_W-1:0] id_q  [SPRITES_PER_LINE];
	logic                 le    [SPRITES_PER_LINE];
	logic [CW-1:0]        count_q;

	// Cells stay sorted by x; a new entry goes after all entries with equal x.
	always_comb begin
		for (int k = 0; k < SPRITES_PER_LINE; k++) begin
			le[k] = vld_q[k] && (x_q[k] <= ctl.x);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SPRITES_PER_LINE; k++) begin
				vld_q[k] <= 1'b0;
			end
			count_q <= '0;
		end else if (ctl.clear) begin
			for (int k = 0; k < SPRITES_PER_LINE; k++) begin
				vld_q[k] <= 1'b0;
			end
			count_q <= '0;
		end else if (ctl.push) begin
			for (int k = 0; k < SPRITES_PER_LINE; k++) begin
				if (!le[k]) begin
					if (k == 0) begin
						vld_q[k] <= 1'b1;
					end else if (le[k-1]) begin
						vld_q[k] <= 1'b1;
					end else begin
						vld_q[k] <= vld_q[k-1];
					end
				end
			end
			if (count_q != CW'(SPRITES_PER_LINE)) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push && !ctl.clear) begin
			for (int k = 0; k < SPRITES_PER_LINE; k++) begin
				if (!le[k]) begin
					if (k == 0) begin
						x_q[k]  <= ctl.x;
						id_q[k] <= ctl.idx;
					end else if (le[k-1]) begin
						x_q[k]  <= ctl.x;
						id_q[k] <= ctl.idx;
					end else begin
						x_q[k]  <= x_q[k-1];
						id_q[k] <= id_q[k-1];
					end
				end
			end
		end
	end

	assign rd_idx = id_q[rd_sel];
	assign count  = count_q;
endmodule

FILE: rtl/tile_sprite_scanline_renderer.sv
`timescale 1ns / 1ps

// Tile map and sprite line renderer.
// Input words arrive on a valid/ready channel: operation 0 writes one byte of
// the 8 KiB video memory, operation 1 writes one byte of the sprite table and
// operation 2 renders one screen line. A write gives no output. A render
// gives LINE_WIDTH/4 output words of four 2-bit shades, in group order,
// with last set on the final group.
// A render first works through each pixel for background and window, each
// layer fetch being three reads of the video memory through its one read
// port, then scans all SPRITE_COUNT sprite entries, draws each selected
// sprite and reads out the output groups. Only one word is worked on at a time.
// After reset the block clears the video memory and the sprite table, one
// entry per cycle, and takes no input word meanwhile.
// Configuration writes are taken at any time and must only be made while idle.
// When the receiver stalls, the output register holds its word and the render
// waits before loading the next group.

module tile_sprite_scanline_renderer #(
	parameter int LINE_WIDTH       = tssr_pkg::LINE_WIDTH_DEF,
	parameter int SPRITES_PER_LINE = tssr_pkg::SPRITES_PER_LINE_DEF,
	parameter int SPRITE_COUNT     = tssr_pkg::SPRITE_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [tssr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data,
	tssr_in_if.sink                        in,
	tssr_out_if.source                     out
);
	import tssr_pkg::*;

	localparam int LXW       = $clog2(LINE_WIDTH);
	localparam int GROUPS    = LINE_WIDTH / 4;
	localparam int OW        = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
	localparam int KW        = (SPRITES_PER_LINE > 1) ? $clog2(SPRITES_PER_LINE) : 1;
	localparam int CW        = $clog2(SPRITES_PER_LINE + 1);
	localparam int OAM_BYTES = 4 * SPRITE_COUNT;
	localparam int VM_DEPTH  = 1 << VM_AW;

	cfg_t cfg;

	tssr_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.wdata  (cfg_data),
		.cfg    (cfg)
	);

	state_t state_q, state_d;

	// Memories.
	logic [7:0]       vram_mem [VM_DEPTH];
	logic [7:0]       vram_rdata_q;
	logic             vram_we;
	logic [VM_AW-1:0] vram_waddr, vram_raddr;
	logic [7:0]       vram_wdata;

	logic [31:0]      oam_mem [SPRITE_COUNT];
	logic [31:0]      oam_rdata_q;
	logic             oam_we;
	logic [3:0]       oam_be;
	logic [OW-1:0]    oam_waddr, oam_raddr;
	logic [31:0]      oam_wdata;

	logic [3:0]       lm_mem [LINE_WIDTH];
	logic [3:0]       lm_rdata_q;
	logic             lm_we;
	logic [LXW-1:0]   lm_waddr, lm_raddr;
	logic [3:0]       lm_wdata;

	always_ff @(posedge clk) begin
		if (vram_we) begin
			vram_mem[vram_waddr] <= vram_wdata;
		end
		vram_rdata_q <= vram_mem[vram_raddr];
	end

	always_ff @(posedge clk) begin
		if (oam_we) begin
			for (int b = 0; b < 4; b++) begin
				if (oam_be[b]) begin
					oam_mem[oam_waddr][8*b +: 8] <= oam_wdata[8*b +: 8];
				end
			end
		end
		oam_rdata_q <= oam_mem[oam_raddr];
	end

	always_ff @(posedge clk) begin
		if (lm_we) begin
			lm_mem[lm_waddr] <= lm_wdata;
		end
		lm_rdata_q <= lm_mem[lm_raddr];
	end

	// Datapath registers.
	logic [VM_AW-1:0] clr_q;
	logic [7:0]       line_q;
	logic [LXW-1:0]   x_q;
	logic             layer_q;
	logic [1:0]       bgc_q, finc_q;
	logic [VM_AW-1:0] taddr_q;
	logic [7:0]       lo_q, hi_q;
	logic [OW-1:0]    scan_q, scan_idx_s1;
	logic             scan_v_s1;
	logic [KW-1:0]    k_q;
	logic [7:0]       spx_q, attr_q;
	logic [2:0]       p_q;
	logic [LXW-1:0]   px_q;
	logic [1:0]       ci_q;
	logic [GROUP_W-1:0] g_q;
	logic [1:0]       kk_q, rk_s1;
	logic             rd_s1;
	logic [7:0]       pack_q;
	logic             ovalid_q, olast_q;
	logic [7:0]       opix_q;
	logic [GROUP_W-1:0] ogrp_q;

	// Sprite list.
	sort_ctl_t            sort_ctl;
	logic [SPR_IDX_W-1:0] sel_idx;
	logic [CW-1:0]        sel_count;

	tssr_sprite_sort #(
		.SPRITES_PER_LINE (SPRITES_PER_LINE)
	) u_sort (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (sort_ctl),
		.rd_sel (k_q),
		.rd_idx (sel_idx),
		.count  (sel_count)
	);

	// Layer coordinates.
	logic [7:0] xb8, u8, v8;
	logic       win_ok, win_px, map_sel;
	logic [7:0] tile_no;
	logic [1:0] layer_color;

	assign xb8 = 8'(x_q);
	assign win_ok = cfg.lcd_control[5] && (line_q >= cfg.window_y) &&
		(cfg.window_y <= WIN_Y_MAX) && (cfg.window_x >= WIN_X_MIN) &&
		(cfg.window_x <= WIN_X_MAX);
	assign win_px = win_ok && (({1'b0, xb8} + 9'd7) >= {1'b0, cfg.window_x});

	always_comb begin
		if (layer_q) begin
			u8      = 8'(xb8 + 8'd7 - cfg.window_x);
			v8      = 8'(line_q - cfg.window_y);
			map_sel = cfg.lcd_control[6];
		end else begin
			u8      = 8'(xb8 + cfg.scroll_x);
			v8      = 8'(line_q + cfg.scroll_y);
			map_sel = cfg.lcd_control[3];
		end
	end

	assign tile_no     = vram_rdata_q;
	assign layer_color = shade(cfg.bg_palette,
		{vram_rdata_q[~u8[2:0]], lo_q[~u8[2:0]]});

	// Sprite evaluation.
	logic [8:0] l16, yb9, hgt9, spx9;
	logic       spr_vis, spr_tall, px_in;
	logic [3:0] ty_raw, ty;
	logic [7:0] spr_tile;
	logic [2:0] pbit;
	logic [1:0] spr_ci;

	assign spr_tall = cfg.lcd_control[2];
	assign l16      = {1'b0, line_q} + 9'd16;
	assign hgt9     = spr_tall ? 9'd16 : 9'd8;
	assign yb9      = {1'b0, oam_rdata_q[7:0]};
	assign spr_vis  = (yb9 <= l16) && (l16 < yb9 + hgt9);
	assign ty_raw   = 4'(l16 - yb9);
	assign ty       = oam_rdata_q[30] ? (4'(hgt9 - 9'd1) - ty_raw) : ty_raw;
	assign spr_tile = spr_tall ? {oam_rdata_q[23:17], ty[3]} : oam_rdata_q[23:16];

	assign pbit   = attr_q[5] ? p_q : ~p_q;
	assign spr_ci = {hi_q[pbit], lo_q[pbit]};
	assign spx9   = {1'b0, spx_q} + {6'd0, p_q};
	assign px_in  = (spx9 >= 9'd8) && ((spx9 - 9'd8) < 9'(LINE_WIDTH));

	assign sort_ctl.clear = (state_q == ST_IDLE);
	assign sort_ctl.push  = scan_v_s1 && spr_vis;
	assign sort_ctl.x     = oam_rdata_q[15:8];
	assign sort_ctl.idx   = SPR_IDX_W'(scan_idx_s1);

	logic out_free, out_load;
	assign out_free = !ovalid_q || out.ready;

	// Next state and memory controls.
	always_comb begin
		state_d    = state_q;
		in.ready   = 1'b0;
		vram_we    = 1'b0;
		vram_waddr = clr_q;
		vram_wdata = '0;
		vram_raddr = taddr_q;
		oam_we     = 1'b0;
		oam_be     = 4'hF;
		oam_waddr  = clr_q[OW-1:0];
		oam_wdata  = '0;
		oam_raddr  = scan_q;
		lm_we      = 1'b0;
		lm_waddr   = x_q;
		lm_wdata   = {bgc_q, finc_q};
		lm_raddr   = px_q;
		out_load   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				vram_we = 1'b1;
				oam_we  = 1'b1;
				if (clr_q == VM_AW'(VM_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in.ready = 1'b1;
				if (in.valid) begin
					case (in.operation)
						OP_VRAM: begin
							vram_we    = 1'b1;
							vram_waddr = in.address;
							vram_wdata = in.data;
						end
						OP_OAM: begin
							if (in.address < VM_AW'(OAM_BYTES)) begin
								oam_we    = 1'b1;
								oam_be    = 4'b0001 << in.address[1:0];
								oam_waddr = in.address[OW+1:2];
								oam_wdata = {4{in.data}};
							end
						end
						OP_RENDER: state_d = ST_PX_BEGIN;
						default: begin
						end
					endcase
				end
			end
			ST_PX_BEGIN: state_d = cfg.lcd_control[0] ? ST_F_MAP : ST_PX_WIN;
			ST_PX_WIN:   state_d = win_px ? ST_F_MAP : ST_PX_WRITE;
			ST_F_MAP: begin
				vram_raddr = {2'b11, map_sel, v8[7:3], u8[7:3]};
				state_d    = ST_F_TILE;
			end
			ST_F_TILE: begin
				vram_raddr = {~(cfg.lcd_control[4] | tile_no[7]), tile_no, v8[2:0], 1'b0};
				state_d    = ST_F_LO;
			end
			ST_F_LO: begin
				vram_raddr = taddr_q | VM_AW'(1);
				state_d    = ST_F_HI;
			end
			ST_F_HI: state_d = layer_q ? ST_PX_WRITE : ST_PX_WIN;
			ST_PX_WRITE: begin
				lm_we = 1'b1;
				if (x_q == LXW'(LINE_WIDTH - 1)) begin
					state_d = cfg.lcd_control[1] ? ST_SC_SCAN : ST_OUT_RD;
				end else begin
					state_d = ST_PX_BEGIN;
				end
			end
			ST_SC_SCAN: begin
				if (scan_q == OW'(SPRITE_COUNT - 1)) begin
					state_d = ST_SC_END;
				end
			end
			ST_SC_END:  state_d = ST_SC_DONE;
			ST_SC_DONE: state_d = (sel_count == '0) ? ST_OUT_RD : ST_SP_ATTR;
			ST_SP_ATTR: begin
				oam_raddr = OW'(sel_idx);
				state_d   = ST_SP_ADDR;
			end
			ST_SP_ADDR: begin
				vram_raddr = {1'b0, spr_tile, ty[2:0], 1'b0};
				state_d    = ST_SP_LO;
			end
			ST_SP_LO: begin
				vram_raddr = taddr_q | VM_AW'(1);
				state_d    = ST_SP_HI;
			end
			ST_SP_HI: state_d = ST_SP_PRD;
			ST_SP_PRD: begin
				lm_raddr = LXW'(spx9 - 9'd8);
				if (px_in && (spr_ci != 2'd0)) begin
					state_d = ST_SP_PWR;
				end else if (p_q == 3'd7) begin
					state_d = (k_q == '0) ? ST_OUT_RD : ST_SP_ATTR;
				end
			end
			ST_SP_PWR: begin
				lm_waddr = px_q;
				lm_wdata = {lm_rdata_q[3:2],
					shade(attr_q[4] ? cfg.sprite_palette_b : cfg.sprite_palette_a, ci_q)};
				lm_we    = !(attr_q[7] && (lm_rdata_q[3:2] != 2'd0));
				if (p_q == 3'd7) begin
					state_d = (k_q == '0) ? ST_OUT_RD : ST_SP_ATTR;
				end else begin
					state_d = ST_SP_PRD;
				end
			end
			ST_OUT_RD: begin
				lm_raddr = LXW'({g_q, kk_q});
				if (kk_q == 2'd3) begin
					state_d = ST_OUT_WAIT;
				end
			end
			ST_OUT_WAIT: state_d = ST_OUT_LOAD;
			ST_OUT_LOAD: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = (g_q == GROUP_W'(GROUPS - 1)) ? ST_IDLE : ST_OUT_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			ovalid_q  <= 1'b0;
			scan_v_s1 <= 1'b0;
			rd_s1     <= 1'b0;
		end else begin
			state_q   <= state_d;
			scan_v_s1 <= (state_q == ST_SC_SCAN);
			rd_s1     <= (state_q == ST_OUT_RD);
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (out.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_idx_s1 <= scan_q;
		rk_s1       <= kk_q;
		if (rd_s1) begin
			pack_q[{rk_s1, 1'b0} +: 2] <= lm_rdata_q[1:0];
		end
		if (out_load) begin
			opix_q  <= pack_q;
			ogrp_q  <= g_q;
			olast_q <= (g_q == GROUP_W'(GROUPS - 1));
			g_q     <= g_q + 1'b1;
		end
		case (state_q)
			ST_IDLE: begin
				line_q <= in.line;
				x_q    <= '0;
				scan_q <= '0;
				g_q    <= '0;
				kk_q   <= '0;
			end
			ST_PX_BEGIN: begin
				layer_q <= 1'b0;
				bgc_q   <= 2'd0;
			end
			ST_PX_WIN: begin
				layer_q <= 1'b1;
				finc_q  <= bgc_q;
			end
			ST_F_TILE: taddr_q <= {~(cfg.lcd_control[4] | tile_no[7]), tile_no, v8[2:0], 1'b0};
			ST_F_LO:   lo_q <= vram_rdata_q;
			ST_F_HI: begin
				if (layer_q) begin
					finc_q <= layer_color;
				end else begin
					bgc_q <= layer_color;
				end
			end
			ST_PX_WRITE: x_q <= x_q + 1'b1;
			ST_SC_SCAN:  scan_q <= scan_q + 1'b1;
			ST_SC_DONE:  k_q <= KW'(sel_count - 1'b1);
			ST_SP_ADDR: begin
				taddr_q <= {1'b0, spr_tile, ty[2:0], 1'b0};
				spx_q   <= oam_rdata_q[15:8];
				attr_q  <= oam_rdata_q[31:24];
			end
			ST_SP_LO: lo_q <= vram_rdata_q;
			ST_SP_HI: begin
				hi_q <= vram_rdata_q;
				p_q  <= 3'd0;
			end
			ST_SP_PRD: begin
				px_q <= LXW'(spx9 - 9'd8);
				ci_q <= spr_ci;
				if (!(px_in && (spr_ci != 2'd0))) begin
					p_q <= p_q + 1'b1;
					if (p_q == 3'd7) begin
						k_q <= k_q - 1'b1;
					end
				end
			end
			ST_SP_PWR: begin
				p_q <= p_q + 1'b1;
				if (p_q == 3'd7) begin
					k_q <= k_q - 1'b1;
				end
			end
			ST_OUT_RD: kk_q <= kk_q + 1'b1;
			default: begin
			end
		endcase
	end

	assign out.valid  = ovalid_q;
	assign out.pixels = opix_q;
	assign out.group  = ogrp_q;
	assign out.last   = olast_q;
endmodule

FILE: tb/tssr_line_checker.sv
`timescale 1ns / 1ps

module tssr_line_checker (
	input  logic                           clk,
	input  logic                           cfg_wr_en,
	input  logic [tssr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_data,
	tssr_in_if                             in_ch,
	tssr_out_if                            out_ch,
	output int                             fail_count,
	output int                             words_waiting,
	output int                             words_checked
);
	import tssr_pkg::*;

	typedef struct {
		logic [7:0] pixels;
		logic [5:0] group;
		logic       last;
	} pixel_word_t;

	pixel_word_t expected_words[$];

	logic [7:0] vram[8192];
	logic [7:0] oam[160];
	logic [1:0] line_shades[160];
	logic [1:0] bg_shades[160];
	logic [7:0] lcdc, scx, scy, wxr, wyr, bgp, obp0, obp1;

	initial begin
		foreach (vram[i]) vram[i] = 8'h00;
		foreach (oam[i]) oam[i] = 8'h00;
		foreach (line_shades[i]) line_shades[i] = 2'd0;
		foreach (bg_shades[i]) bg_shades[i] = 2'd0;
		{lcdc, scx, scy, wxr, wyr, bgp, obp0, obp1} = '0;
		fail_count = 0;
		words_waiting = 0;
		words_checked = 0;
	end

	function automatic logic [1:0] pick_shade(input logic [7:0] pal, input logic [1:0] c);
		return pal[c * 2 +: 2];
	endfunction

	function automatic logic [1:0] tile_color(input int map_base, input int row, input int col,
		input int fy, input int fx);
		int t;
		int base;
		int a;
		int b;
		t = vram[(map_base + (row & 31) * 32 + (col & 31)) & 8191];
		if (lcdc[4] || t >= 128) begin
			base = t * 16;
		end else begin
			base = 4096 + t * 16;
		end
		a = (base + (fy & 7) * 2) & 8191;
		b = 7 - (fx & 7);
		return {vram[(a + 1) & 8191][b], vram[a][b]};
	endfunction

	task automatic render_line(input logic [7:0] ln);
		int y;
		int mb;
		int wy;
		int h;
		int cnt;
		int j;
		int n;
		int s;
		int ypos;
		int xpos;
		int ty;
		int a;
		int bsel;
		int px;
		int vis_idx[40];
		int vis_x[40];
		logic [7:0] tile;
		logic [7:0] attr;
		logic [7:0] pal;
		logic [1:0] ci;
		pixel_word_t w;
		if (lcdc[0]) begin
			y = (ln + scy) & 255;
			mb = lcdc[3] ? 'h1C00 : 'h1800;
			for (int x = 0; x < 160; x++) begin
				bg_shades[x] = pick_shade(bgp, tile_color(mb, y >> 3, (x + scx) >> 3, y, x + scx));
				line_shades[x] = bg_shades[x];
			end
		end else begin
			foreach (bg_shades[x]) bg_shades[x] = 2'd0;
			foreach (line_shades[x]) line_shades[x] = 2'd0;
		end
		if (lcdc[5] && !(ln < wyr || wyr > WIN_Y_MAX || wxr < WIN_X_MIN || wxr > WIN_X_MAX)) begin
			wy = ln - wyr;
			mb = lcdc[6] ? 'h1C00 : 'h1800;
			for (int x = 0; x < 160; x++) begin
				if (x + 7 >= wxr) begin
					line_shades[x] = pick_shade(bgp,
						tile_color(mb, wy >> 3, (x + 7 - wxr) >> 3, wy, x + 7 - wxr));
				end
			end
		end
		if (lcdc[1]) begin
			h = lcdc[2] ? 16 : 8;
			cnt = 0;
			for (int i = 0; i < 40; i++) begin
				ypos = int'(oam[i * 4]) - 16;
				if (!(int'(ln) < ypos || int'(ln) >= ypos + h)) begin
					j = cnt;
					while (j > 0 && vis_x[j - 1] > int'(oam[i * 4 + 1])) begin
						vis_x[j] = vis_x[j - 1];
						vis_idx[j] = vis_idx[j - 1];
						j--;
					end
					vis_x[j] = oam[i * 4 + 1];
					vis_idx[j] = i;
					cnt++;
				end
			end
			n = (cnt > 10) ? 10 : cnt;
			for (int k = n; k > 0; k--) begin
				s = vis_idx[k - 1] * 4;
				ypos = int'(oam[s]) - 16;
				xpos = int'(oam[s + 1]) - 8;
				tile = oam[s + 2];
				attr = oam[s + 3];
				ty = int'(ln) - ypos;
				if (attr[6]) ty = h - 1 - ty;
				if (h == 16) begin
					tile[0] = 1'b0;
					if (ty >= 8) begin
						tile[0] = 1'b1;
						ty -= 8;
					end
				end
				a = (int'(tile) * 16 + (ty & 7) * 2) & 8191;
				pal = attr[4] ? obp1 : obp0;
				for (int x = 0; x < 8; x++) begin
					px = xpos + x;
					bsel = attr[5] ? x : 7 - x;
					ci = {vram[(a + 1) & 8191][bsel], vram[a][bsel]};
					if (px >= 0 && px < 160 && ci != 2'd0 && !(attr[7] && bg_shades[px] != 2'd0))
						line_shades[px] = pick_shade(pal, ci);
				end
			end
		end
		for (int g = 0; g < 40; g++) begin
			w.pixels = {line_shades[g * 4 + 3], line_shades[g * 4 + 2],
				line_shades[g * 4 + 1], line_shades[g * 4]};
			w.group = g[5:0];
			w.last = (g == 39);
			expected_words.push_back(w);
		end
	endtask

	always @(posedge clk) begin
		pixel_word_t e;
		if (cfg_wr_en) begin
			case (cfg_index)
				REG_LCD_CONTROL: lcdc = cfg_data;
				REG_SCROLL_X:    scx = cfg_data;
				REG_SCROLL_Y:    scy = cfg_data;
				REG_WINDOW_X:    wxr = cfg_data;
				REG_WINDOW_Y:    wyr = cfg_data;
				REG_BG_PAL:      bgp = cfg_data;
				REG_SPR_PAL_A:   obp0 = cfg_data;
				REG_SPR_PAL_B:   obp1 = cfg_data;
				default: ;
			endcase
		end
		if (out_ch.valid && out_ch.ready) begin
			words_checked++;
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word pixels=%h group=%0d last=%b", $time,
					out_ch.pixels, out_ch.group, out_ch.last);
				fail_count++;
			end else begin
				e = expected_words.pop_front();
				if (out_ch.pixels !== e.pixels || out_ch.group !== e.group
					|| out_ch.last !== e.last) begin
					$display("%0t: mismatch expected pixels=%h group=%0d last=%b, got pixels=%h group=%0d last=%b",
						$time, e.pixels, e.group, e.last, out_ch.pixels, out_ch.group,
						out_ch.last);
					fail_count++;
				end
			end
		end
		if (in_ch.valid && in_ch.ready) begin
			case (in_ch.operation)
				OP_VRAM: vram[in_ch.address] = in_ch.data;
				OP_OAM: begin
					if (in_ch.address < 160) oam[in_ch.address] = in_ch.data;
				end
				OP_RENDER: render_line(in_ch.line);
				default: ;
			endcase
		end
		words_waiting = expected_words.size();
	end
endmodule

FILE: tb/tile_sprite_scanline_renderer_tb.sv
`timescale 1ns / 1ps

module tile_sprite_scanline_renderer_tb;
	import tssr_pkg::*;

	localparam int IDLE_LIMIT = 40000;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0] cfg_data;
	int fail_count;
	int words_waiting;
	int words_checked;
	int burst_left;
	int stall_mode;
	int stall_left;
	int idle_cycles;
	int render_count;
	int write_count;

	tssr_in_if in_ch();
	tssr_out_if out_ch();

	tile_sprite_scanline_renderer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in(in_ch),
		.out(out_ch)
	);

	tssr_line_checker i_checker (
		.clk(clk),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.fail_count(fail_count),
		.words_waiting(words_waiting),
		.words_checked(words_checked)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(10, 200);
		end
		stall_left--;
		case (stall_mode)
			0: out_ch.ready <= 1'b1;
			1: out_ch.ready <= 1'($urandom_range(0, 1));
			2: out_ch.ready <= ($urandom_range(0, 7) == 0);
			default: out_ch.ready <= ((stall_left % 16) < 12);
		endcase
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_wr_en) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL tile_sprite_scanline_renderer");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_word(input logic [1:0] op, input logic [12:0] addr,
		input logic [7:0] dat, input logic [7:0] ln);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_ch.operation = op;
		in_ch.address = addr;
		in_ch.data = dat;
		in_ch.line = ln;
		in_ch.valid = 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
		if (op == OP_RENDER) render_count++;
		else write_count++;
	endtask

	task automatic settle;
		in_ch.valid = 1'b0;
		do @(negedge clk); while (words_waiting != 0);
		repeat (30) @(negedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		cfg_index = idx;
		cfg_data = val;
		cfg_wr_en = 1'b1;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	function automatic logic [7:0] edge_byte();
		case ($urandom_range(0, 3))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic random_config;
		logic [7:0] wx;
		case ($urandom_range(0, 5))
			0: wx = WIN_X_MIN;
			1: wx = WIN_X_MAX;
			2: wx = WIN_X_MIN - 8'd1;
			3: wx = WIN_X_MAX + 8'd1;
			default: wx = 8'($urandom_range(0, 255));
		endcase
		set_reg(REG_LCD_CONTROL, 8'($urandom_range(0, 255)));
		set_reg(REG_SCROLL_X, edge_byte());
		set_reg(REG_SCROLL_Y, edge_byte());
		set_reg(REG_WINDOW_X, wx);
		set_reg(REG_WINDOW_Y,
			($urandom_range(0, 3) == 0) ? edge_byte() : 8'($urandom_range(0, 150)));
		set_reg(REG_BG_PAL, edge_byte());
		set_reg(REG_SPR_PAL_A, edge_byte());
		set_reg(REG_SPR_PAL_B, edge_byte());
	endtask

	task automatic random_word;
		logic [12:0] addr;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			addr = ($urandom_range(0, 1) == 0) ? 13'($urandom_range(0, 'h0FFF))
				: 13'($urandom_range(0, 'h1FFF));
			send_word(OP_VRAM, addr, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		end else if (pick < 60) begin
			addr = 13'($urandom_range('h1800, 'h1FFF));
			send_word(OP_VRAM, addr, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		end else if (pick < 82) begin
			addr = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 8191))
				: 13'($urandom_range(0, 159));
			send_word(OP_OAM, addr,
				(addr % 4 == 0) ? 8'($urandom_range(8, 170)) : 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)));
		end else if (pick < 98) begin
			send_word(OP_RENDER, 13'($urandom_range(0, 8191)), 8'($urandom_range(0, 255)),
				($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
					: 8'($urandom_range(0, 143)));
		end else begin
			send_word(OP_UNUSED, 13'($urandom_range(0, 8191)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		logic [7:0] crowd_y;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.operation = OP_VRAM;
		in_ch.address = '0;
		in_ch.data = '0;
		in_ch.line = '0;
		out_ch.ready = 1'b0;
		burst_left = 0;
		stall_mode = 0;
		stall_left = 0;
		idle_cycles = 0;
		render_count = 0;
		write_count = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_word(OP_RENDER, 13'd0, 8'd0, 8'd0);
		settle();
		set_reg(REG_LCD_CONTROL, 8'hF7);
		set_reg(REG_SCROLL_X, 8'd0);
		set_reg(REG_SCROLL_Y, 8'd0);
		set_reg(REG_WINDOW_X, WIN_X_MAX);
		set_reg(REG_WINDOW_Y, WIN_Y_MAX);
		set_reg(REG_BG_PAL, 8'hE4);
		set_reg(REG_SPR_PAL_A, 8'h1B);
		set_reg(REG_SPR_PAL_B, 8'hFF);
		send_word(OP_VRAM, 13'h0010, 8'hFF, 8'd0);
		send_word(OP_VRAM, 13'h0011, 8'h0F, 8'd0);
		send_word(OP_VRAM, 13'h1800, 8'h01, 8'd0);
		send_word(OP_VRAM, 13'h1FFF, 8'hFF, 8'd0);
		send_word(OP_VRAM, 13'h1080, 8'hAA, 8'd0);
		send_word(OP_OAM, 13'd0, 8'd16, 8'd0);
		send_word(OP_OAM, 13'd1, 8'd4, 8'd0);
		send_word(OP_OAM, 13'd2, 8'd1, 8'd0);
		send_word(OP_OAM, 13'd3, 8'hF0, 8'd0);
		send_word(OP_OAM, 13'd159, 8'hFF, 8'd0);
		send_word(OP_OAM, 13'd160, 8'h55, 8'd0);
		send_word(OP_OAM, 13'h1FFF, 8'h55, 8'd0);
		send_word(OP_UNUSED, 13'h1FFF, 8'hFF, 8'hFF);
		send_word(OP_RENDER, 13'd0, 8'd0, 8'd0);
		send_word(OP_RENDER, 13'd0, 8'd0, 8'd143);
		send_word(OP_RENDER, 13'h1FFF, 8'hFF, 8'd255);
		settle();
		set_reg(REG_LCD_CONTROL, 8'h00);
		set_reg(REG_WINDOW_X, WIN_X_MIN);
		set_reg(REG_WINDOW_Y, 8'd0);
		send_word(OP_RENDER, 13'd0, 8'd0, 8'd3);
		settle();
		set_reg(REG_LCD_CONTROL, 8'hFF);
		send_word(OP_RENDER, 13'd0, 8'd0, 8'd1);
		send_word(OP_RENDER, 13'd0, 8'd0, 8'd9);

		for (int phase = 0; phase < 10; phase++) begin
			settle();
			random_config();
			if ($urandom_range(0, 2) == 0) begin
				crowd_y = 8'($urandom_range(16, 150));
				for (int s = 0; s < 40; s++)
					send_word(OP_OAM, 13'(s * 4), 8'(crowd_y + $urandom_range(0, 3)), 8'd0);
				send_word(OP_RENDER, 13'd0, 8'd0, crowd_y - 8'd12);
			end
			repeat (16) random_word();
		end
		settle();
		$display("Covered %0d renders and %0d writes, %0d pixel words checked.",
			render_count, write_count, words_checked);
		if (fail_count == 0) begin
			$display("PASS tile_sprite_scanline_renderer");
		end else begin
			$display("FAIL tile_sprite_scanline_renderer");
		end
		$finish;
	end
endmodule
